// ----- hw/rtl/width_configurable_checked_int_alu_core_defines.svh -----
// Assertion helpers for the checked integer ALU; expect clk and rst_n in scope.
`ifndef WIDTH_CONFIGURABLE_CHECKED_INT_ALU_CORE_DEFINES_SVH
`define WIDTH_CONFIGURABLE_CHECKED_INT_ALU_CORE_DEFINES_SVH

// Same-cycle implication.
`define WCAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WCAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wcal_pkg.sv -----
`default_nettype none

package wcal_pkg;

    localparam logic [3:0] MODE_ADD = 4'd0;
    localparam logic [3:0] MODE_SUB = 4'd1;
    localparam logic [3:0] MODE_MUL = 4'd2;
    localparam logic [3:0] MODE_DIV = 4'd3;
    localparam logic [3:0] MODE_MOD = 4'd4;
    localparam logic [3:0] MODE_NEG = 4'd5;
    localparam logic [3:0] MODE_SHL = 4'd6;
    localparam logic [3:0] MODE_SHR = 4'd7;
    localparam logic [3:0] MODE_NOT = 4'd8;

    localparam logic [1:0] POL_CHECKED = 2'd0;
    localparam logic [1:0] POL_WRAP    = 2'd1;
    localparam logic [1:0] POL_SAT     = 2'd2;
    localparam logic [1:0] POL_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;
    localparam logic [1:0] ST_SHIFT = 2'd3;

    typedef struct packed {
        logic [3:0]  mode;
        logic        is_signed;
        logic [1:0]  policy;
        logic [6:0]  width;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } alu_cmd_t;

    typedef struct packed {
        logic [63:0] result;
        logic [1:0]  status;
    } alu_rsp_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic        sg;
        logic        na;
        logic        nb;
        logic [6:0]  w;
        logic [1:0]  status;
        logic [63:0] val;
    } meta_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] val;
    } pol_res_t;

    function automatic logic [63:0] wmask(input logic [6:0] w);
        logic [63:0] m;
        if (w >= 7'd64)
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << w) - 64'd1;
        end
        return m;
    endfunction

    function automatic logic [63:0] sext64(input logic [63:0] x, input logic [6:0] w);
        logic [63:0] m;
        logic [63:0] r;
        logic [5:0]  idx;
        m   = wmask(w);
        r   = x & m;
        idx = 6'(w - 7'd1);
        if (w < 7'd64 && r[idx])
        begin
            r = r | ~m;
        end
        return r;
    endfunction

    function automatic pol_res_t apply_policy(input logic [1:0] pol, input logic [63:0] wv,
                                              input logic ovf, input logic [63:0] sv);
        pol_res_t pr;
        pr.val    = wv;
        pr.status = ST_OK;
        unique case (pol)
            POL_WRAP:
            begin
                pr.val = wv;
            end
            POL_SAT:
            begin
                pr.val = ovf ? sv : wv;
            end
            POL_CHECKED, POL_UNUSED:
            begin
                pr.status = ovf ? ST_OVF : ST_OK;
            end
        endcase
        return pr;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wcal_div.sv -----
`default_nettype none

module wcal_div
    import wcal_pkg::*;
#(
    parameter int DW = 64
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    input  wire meta_t         meta,
    output logic               q_valid,
    output logic [DW-1:0]      quotient,
    output logic [DW-1:0]      remainder,
    output meta_t              q_meta
);

    logic          valid_reg [DW];
    logic [DW-1:0] rem_reg   [DW];
    logic [DW-1:0] qd_reg    [DW];
    logic [DW-1:0] dsr_reg   [DW];
    meta_t         meta_reg  [DW];
    logic [DW-1:0] rem_next  [DW];
    logic [DW-1:0] qd_next   [DW];

    always_comb
    begin
        logic [DW-1:0] s_rem;
        logic [DW-1:0] s_qd;
        logic [DW-1:0] s_dsr;
        logic [DW:0]   trial;
        logic          ge;
        int            p;
        for (int k = 0; k < DW; k++)
        begin
            p = (k > 0) ? k - 1 : 0;
            if (k == 0)
            begin
                s_rem = '0;
                s_qd  = dividend;
                s_dsr = divisor;
            end
            else
            begin
                s_rem = rem_reg[p];
                s_qd  = qd_reg[p];
                s_dsr = dsr_reg[p];
            end
            trial       = {s_rem, s_qd[DW-1]};
            ge          = (trial >= {1'b0, s_dsr});
            rem_next[k] = ge ? DW'(trial - {1'b0, s_dsr}) : trial[DW-1:0];
            qd_next[k]  = {s_qd[DW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DW; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= valid;
            for (int k = 1; k < DW; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dsr_reg[0]  <= divisor;
        meta_reg[0] <= meta;
        for (int k = 0; k < DW; k++)
        begin
            rem_reg[k] <= rem_next[k];
            qd_reg[k]  <= qd_next[k];
        end
        for (int k = 1; k < DW; k++)
        begin
            dsr_reg[k]  <= dsr_reg[k-1];
            meta_reg[k] <= meta_reg[k-1];
        end
    end

    assign q_valid   = valid_reg[DW-1];
    assign quotient  = qd_reg[DW-1];
    assign remainder = rem_reg[DW-1];
    assign q_meta    = meta_reg[DW-1];

endmodule

`default_nettype wire

// ----- hw/rtl/width_configurable_checked_int_alu_core.sv -----
// Checked integer ALU with per-beat width, signedness and overflow policy.
// Command channel: drive cmd and raise start; a beat is taken at each rising
// edge with start high and busy low. busy stays low, so a beat may enter on
// every cycle.
// Response channel: done pulses for one cycle with rsp holding result and
// status. The receiver cannot stall; every response must be taken when shown.
// Every operation passes the operand stage, the ALU and partial-product stage,
// the divider stages and the response register, so responses keep order.
// Throughput: one beat per cycle. The divider resolves one quotient bit per
// stage over DATA_WIDTH stages; the multiplier forms four 32x32 partial
// products in one stage and combines them in the next.
// Reset clears all valid bits; beats in flight are dropped and done stays low.
`default_nettype none
`include "width_configurable_checked_int_alu_core_defines.svh"

module width_configurable_checked_int_alu_core
    import wcal_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire alu_cmd_t cmd,
    output logic          done,
    output alu_rsp_t      rsp
);

    localparam int LAT = DATA_WIDTH + 3;

    logic accept;

    logic        a_valid_reg;
    logic [3:0]  a_mode_reg;
    logic        a_sg_reg;
    logic [1:0]  a_pol_reg;
    logic [6:0]  a_w_reg;
    logic [63:0] a_m_reg;
    logic [63:0] a_a_reg;
    logic [63:0] a_b_reg;
    logic [63:0] a_n_reg;
    logic        a_na_reg;
    logic        a_nb_reg;
    logic [63:0] a_ma_reg;
    logic [63:0] a_mb_reg;

    logic [6:0]  a_w_next;
    logic [1:0]  a_pol_next;
    logic [63:0] a_m_next;
    logic [63:0] a_a_next;
    logic [63:0] a_b_next;
    logic        a_na_next;
    logic        a_nb_next;

    logic        b_valid_reg;
    meta_t       b_meta_reg;
    logic [1:0]  b_pol_reg;
    logic [63:0] b_ll_reg;
    logic [63:0] b_lh_reg;
    logic [63:0] b_hl_reg;
    logic [63:0] b_hh_reg;
    logic [63:0] b_ma_reg;
    logic [63:0] b_mb_reg;

    meta_t       b_meta_next;
    logic [63:0] b_smax;
    logic [63:0] b_smin;
    logic [63:0] b_sum;
    logic [63:0] b_dif;
    logic [63:0] b_o;
    logic [63:0] b_wv;
    logic [63:0] b_sv;
    logic        b_ovf;
    logic        b_policed;
    pol_res_t    b_pr;

    meta_t       c_meta;
    logic [63:0] c_m;
    logic [63:0] c_smax;
    logic [65:0] c_mid;
    logic [63:0] c_lo;
    logic [63:0] c_hi;
    logic [63:0] c_wv;
    logic [63:0] c_sv;
    logic        c_ovf;
    pol_res_t    c_pr;

    logic                  d_valid;
    logic [DATA_WIDTH-1:0] d_quo;
    logic [DATA_WIDTH-1:0] d_rem;
    meta_t                 d_meta;

    logic [63:0] o_q;
    logic [63:0] o_r;
    logic [63:0] o_val;
    alu_rsp_t    rsp_next;
    logic        done_reg;
    alu_rsp_t    rsp_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        if (cmd.width == 7'd0)
        begin
            a_w_next = 7'd1;
        end
        else if (cmd.width > 7'(DATA_WIDTH))
        begin
            a_w_next = 7'(DATA_WIDTH);
        end
        else
        begin
            a_w_next = cmd.width;
        end
        a_pol_next = (cmd.policy == POL_UNUSED) ? POL_CHECKED : cmd.policy;
        a_m_next   = wmask(a_w_next);
        a_a_next   = cmd.is_signed ? sext64(cmd.operand_a, a_w_next) : (cmd.operand_a & a_m_next);
        a_b_next   = cmd.is_signed ? sext64(cmd.operand_b, a_w_next) : (cmd.operand_b & a_m_next);
        a_na_next  = cmd.is_signed && a_a_next[63];
        a_nb_next  = cmd.is_signed && a_b_next[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            done_reg    <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mode_reg <= cmd.mode;
        a_sg_reg   <= cmd.is_signed;
        a_pol_reg  <= a_pol_next;
        a_w_reg    <= a_w_next;
        a_m_reg    <= a_m_next;
        a_a_reg    <= a_a_next;
        a_b_reg    <= a_b_next;
        a_n_reg    <= cmd.operand_b;
        a_na_reg   <= a_na_next;
        a_nb_reg   <= a_nb_next;
        a_ma_reg   <= a_na_next ? -a_a_next : a_a_next;
        a_mb_reg   <= a_nb_next ? -a_b_next : a_b_next;
    end

    always_comb
    begin
        b_smax    = a_m_reg >> 1;
        b_smin    = ~b_smax;
        b_sum     = a_a_reg + a_b_reg;
        b_dif     = a_a_reg - a_b_reg;
        b_o       = '0;
        b_wv      = '0;
        b_sv      = '0;
        b_ovf     = 1'b0;
        b_policed = 1'b0;
        b_meta_next.mode   = a_mode_reg;
        b_meta_next.sg     = a_sg_reg;
        b_meta_next.na     = a_na_reg;
        b_meta_next.nb     = a_nb_reg;
        b_meta_next.w      = a_w_reg;
        b_meta_next.status = ST_OK;
        b_meta_next.val    = '0;
        unique case (a_mode_reg)
            MODE_ADD:
            begin
                b_policed = 1'b1;
                b_wv      = b_sum;
                if (a_sg_reg)
                begin
                    b_o   = ~(a_a_reg ^ a_b_reg) & (a_a_reg ^ b_sum);
                    b_ovf = b_o[63] || (sext64(b_sum, a_w_reg) != b_sum);
                    b_sv  = a_a_reg[63] ? b_smin : b_smax;
                end
                else
                begin
                    b_ovf = (b_sum < a_a_reg) || (b_sum > a_m_reg);
                    b_sv  = a_m_reg;
                end
            end
            MODE_SUB:
            begin
                b_policed = 1'b1;
                b_wv      = b_dif;
                if (a_sg_reg)
                begin
                    b_o   = (a_a_reg ^ a_b_reg) & (a_a_reg ^ b_dif);
                    b_ovf = b_o[63] || (sext64(b_dif, a_w_reg) != b_dif);
                    b_sv  = a_a_reg[63] ? b_smin : b_smax;
                end
                else
                begin
                    b_ovf = a_a_reg < a_b_reg;
                    b_sv  = '0;
                end
            end
            MODE_DIV, MODE_MOD:
            begin
                if (a_b_reg == '0)
                begin
                    b_meta_next.status = ST_DIV0;
                end
                else if (a_sg_reg && a_a_reg == b_smin && a_b_reg == '1)
                begin
                    b_meta_next.status = ST_OVF;
                end
            end
            MODE_NEG:
            begin
                b_policed = 1'b1;
                b_wv      = -a_a_reg;
                if (a_sg_reg)
                begin
                    b_ovf = a_a_reg == b_smin;
                    b_sv  = b_smax;
                end
                else
                begin
                    b_ovf = a_a_reg != '0;
                    b_sv  = '0;
                end
            end
            MODE_SHL, MODE_SHR:
            begin
                if (a_n_reg >= 64'(a_w_reg))
                begin
                    b_meta_next.status = ST_SHIFT;
                end
                else if (a_mode_reg == MODE_SHL)
                begin
                    b_meta_next.val = a_a_reg << a_n_reg[5:0];
                end
                else if (a_sg_reg)
                begin
                    b_meta_next.val = 64'($signed(a_a_reg) >>> a_n_reg[5:0]);
                end
                else
                begin
                    b_meta_next.val = a_a_reg >> a_n_reg[5:0];
                end
            end
            MODE_NOT:
            begin
                b_meta_next.val = ~a_a_reg;
            end
            default:
            begin
                b_meta_next.val = '0;
            end
        endcase
        b_pr = apply_policy(a_pol_reg, b_wv, b_ovf, b_sv);
        if (b_policed)
        begin
            b_meta_next.val    = b_pr.val;
            b_meta_next.status = b_pr.status;
        end
    end

    always_ff @(posedge clk)
    begin
        b_meta_reg <= b_meta_next;
        b_pol_reg  <= a_pol_reg;
        b_ll_reg   <= 64'(a_ma_reg[31:0])  * 64'(a_mb_reg[31:0]);
        b_lh_reg   <= 64'(a_ma_reg[31:0])  * 64'(a_mb_reg[63:32]);
        b_hl_reg   <= 64'(a_ma_reg[63:32]) * 64'(a_mb_reg[31:0]);
        b_hh_reg   <= 64'(a_ma_reg[63:32]) * 64'(a_mb_reg[63:32]);
        b_ma_reg   <= a_ma_reg;
        b_mb_reg   <= a_mb_reg;
    end

    always_comb
    begin
        c_m    = wmask(b_meta_reg.w);
        c_smax = c_m >> 1;
        c_mid  = 66'(b_ll_reg[63:32]) + 66'(b_lh_reg[31:0]) + 66'(b_hl_reg[31:0]);
        c_lo   = {c_mid[31:0], b_ll_reg[31:0]};
        c_hi   = b_hh_reg + 64'(b_lh_reg[63:32]) + 64'(b_hl_reg[63:32]) + 64'(c_mid[65:32]);
        c_wv   = (b_meta_reg.na != b_meta_reg.nb) ? -c_lo : c_lo;
        if (b_meta_reg.sg)
        begin
            if (b_meta_reg.na != b_meta_reg.nb && c_lo != '0)
            begin
                c_ovf = (c_hi != '0) || (c_lo > c_smax + 64'd1);
            end
            else
            begin
                c_ovf = (c_hi != '0) || (c_lo > c_smax);
            end
            c_sv = (b_meta_reg.na != b_meta_reg.nb) ? ~c_smax : c_smax;
        end
        else
        begin
            c_ovf = (c_hi != '0) || (c_lo > c_m);
            c_sv  = c_m;
        end
        c_pr   = apply_policy(b_pol_reg, c_wv, c_ovf, c_sv);
        c_meta = b_meta_reg;
        if (b_meta_reg.mode == MODE_MUL)
        begin
            c_meta.val    = c_pr.val;
            c_meta.status = c_pr.status;
        end
    end

    wcal_div #(
        .DW (DATA_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (b_valid_reg),
        .dividend  (b_ma_reg[DATA_WIDTH-1:0]),
        .divisor   (b_mb_reg[DATA_WIDTH-1:0]),
        .meta      (c_meta),
        .q_valid   (d_valid),
        .quotient  (d_quo),
        .remainder (d_rem),
        .q_meta    (d_meta)
    );

    always_comb
    begin
        o_q   = 64'(d_quo);
        o_r   = 64'(d_rem);
        o_val = d_meta.val;
        if (d_meta.mode == MODE_DIV)
        begin
            o_val = (d_meta.na != d_meta.nb) ? -o_q : o_q;
        end
        else if (d_meta.mode == MODE_MOD)
        begin
            o_val = d_meta.na ? -o_r : o_r;
        end
        rsp_next.status = d_meta.status;
        if (d_meta.status != ST_OK)
        begin
            rsp_next.result = '0;
        end
        else if (d_meta.sg)
        begin
            rsp_next.result = sext64(o_val, d_meta.w);
        end
        else
        begin
            rsp_next.result = o_val & wmask(d_meta.w);
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `WCAL_ASSERT_NOW(a_done_from_start, done, $past(start, LAT), "response without command")
    `WCAL_ASSERT_NOW(a_err_zero, done && rsp.status != ST_OK, rsp.result == '0,
                     "nonzero result on error")
    `WCAL_ASSERT_NEXT(a_start_tracked, start, a_valid_reg, "accepted beat lost in first stage")
    `WCAL_ASSERT_NOW(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

`default_nettype wire

// ----- dv/alu_checker.sv -----
`default_nettype none

module alu_checker
    import wcal_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     busy,
    input  wire alu_cmd_t cmd,
    input  wire logic     done,
    input  wire alu_rsp_t rsp,
    output int            fail_count,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    alu_rsp_t expected_q[$];

    function automatic logic [63:0] width_mask(input int unsigned w);
        if (w >= 64)
        begin
            return '1;
        end
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [63:0] fit_signed(input logic [63:0] x, input int unsigned w);
        logic [63:0] m;
        m = width_mask(w);
        x = x & m;
        if (w < 64 && x[w - 1])
        begin
            x = x | ~m;
        end
        return x;
    endfunction

    function automatic alu_rsp_t compute_alu(input alu_cmd_t c);
        int unsigned w;
        logic [1:0]   pol;
        logic [63:0]  m, smax, smin, a, b, wv, sv, val, ma, mb;
        logic [127:0] prod;
        logic         ovf, policed, na, nb;
        logic [1:0]   st;
        alu_rsp_t     r;
        w = c.width;
        if (w == 0)
        begin
            w = 1;
        end
        if (w > 64)
        begin
            w = 64;
        end
        pol = (c.policy == POL_UNUSED) ? POL_CHECKED : c.policy;
        m = width_mask(w);
        smax = m >> 1;
        smin = ~smax;
        a = c.is_signed ? fit_signed(c.operand_a, w) : (c.operand_a & m);
        b = c.is_signed ? fit_signed(c.operand_b, w) : (c.operand_b & m);
        na = a[63];
        nb = b[63];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        wv = '0;
        sv = '0;
        val = '0;
        ovf = 1'b0;
        policed = 1'b0;
        st = ST_OK;
        case (c.mode)
            MODE_ADD, MODE_SUB:
            begin
                policed = 1'b1;
                wv = (c.mode == MODE_ADD) ? a + b : a - b;
                if (c.is_signed)
                begin
                    ovf = (c.mode == MODE_ADD) ? (~(a[63] ^ b[63]) & (a[63] ^ wv[63]))
                                               : ((a[63] ^ b[63]) & (a[63] ^ wv[63]));
                    ovf = ovf || (fit_signed(wv, w) != wv);
                    sv = na ? smin : smax;
                end
                else if (c.mode == MODE_ADD)
                begin
                    ovf = (wv < a) || (wv > m);
                    sv = m;
                end
                else
                begin
                    ovf = a < b;
                end
            end
            MODE_MUL:
            begin
                policed = 1'b1;
                wv = a * b;
                if (c.is_signed)
                begin
                    prod = {64'd0, ma} * {64'd0, mb};
                    if (na != nb && prod[63:0] != 0)
                    begin
                        ovf = (prod[127:64] != 0) || (prod[63:0] > smax + 64'd1);
                    end
                    else
                    begin
                        ovf = (prod[127:64] != 0) || (prod[63:0] > smax);
                    end
                    sv = (na != nb) ? smin : smax;
                end
                else
                begin
                    prod = {64'd0, a} * {64'd0, b};
                    ovf = (prod[127:64] != 0) || (prod[63:0] > m);
                    sv = m;
                end
            end
            MODE_DIV, MODE_MOD:
            begin
                if (b == 0)
                begin
                    st = ST_DIV0;
                end
                else if (c.is_signed && a == smin && b == '1)
                begin
                    st = ST_OVF;
                end
                else if (c.is_signed)
                begin
                    if (c.mode == MODE_DIV)
                    begin
                        val = ma / mb;
                        if (na != nb)
                        begin
                            val = -val;
                        end
                    end
                    else
                    begin
                        val = ma % mb;
                        if (na)
                        begin
                            val = -val;
                        end
                    end
                end
                else
                begin
                    val = (c.mode == MODE_DIV) ? a / b : a % b;
                end
            end
            MODE_NEG:
            begin
                policed = 1'b1;
                wv = -a;
                ovf = c.is_signed ? (a == smin) : (a != 0);
                sv = c.is_signed ? smax : 64'd0;
            end
            MODE_SHL, MODE_SHR:
            begin
                if (c.operand_b >= 64'(w))
                begin
                    st = ST_SHIFT;
                end
                else if (c.mode == MODE_SHL)
                begin
                    val = a << c.operand_b[5:0];
                end
                else
                begin
                    val = c.is_signed ? 64'($signed(a) >>> c.operand_b[5:0])
                                      : a >> c.operand_b[5:0];
                end
            end
            MODE_NOT:
            begin
                val = ~a;
            end
            default:
            begin
                val = '0;
            end
        endcase
        if (policed)
        begin
            val = wv;
            if (pol == POL_CHECKED && ovf)
            begin
                st = ST_OVF;
            end
            else if (pol == POL_SAT && ovf)
            begin
                val = sv;
            end
        end
        if (st != ST_OK)
        begin
            val = '0;
        end
        else
        begin
            val = c.is_signed ? fit_signed(val, w) : (val & m);
        end
        r.result = val;
        r.status = st;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        alu_rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.result !== want.result)
                    begin
                        $error("result: expected %h, actual %h", want.result, rsp.result);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_q.push_back(compute_alu(cmd));
            end
        end
    end
endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none

module tb
    import wcal_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    logic     done;
    alu_cmd_t cmd = '0;
    alu_rsp_t rsp;
    int       fail_count;
    int       pending;

    always #4 clk = ~clk;

    width_configurable_checked_int_alu_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    alu_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_operand(input int unsigned w);
        logic [63:0] m;
        m = (w >= 64) ? '1 : (64'd1 << w) - 64'd1;
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            2: return m >> 1;
            3: return ~(m >> 1);
            4: return 64'($urandom_range(0, 3));
            5: return rand64() & m;
            default: return rand64();
        endcase
    endfunction

    // send one beat, after a random gap when gaps is set; hold start when no gap follows
    task automatic send_beat(input alu_cmd_t c, input bit gaps);
        int unsigned gap;
        gap = gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    function automatic alu_cmd_t random_cmd();
        alu_cmd_t c;
        c.mode      = 4'($urandom_range(0, 20) > 18 ? $urandom_range(9, 15) : $urandom_range(0, 8));
        c.is_signed = 1'($urandom_range(0, 1));
        c.policy    = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0: c.width = 7'd1;
            1: c.width = 7'd64;
            2: c.width = 7'($urandom_range(0, 127));
            3: c.width = 7'($urandom_range(1, 8));
            default: c.width = 7'($urandom_range(1, 64));
        endcase
        c.operand_a = pick_operand(c.width);
        c.operand_b = pick_operand(c.width);
        if ((c.mode == MODE_SHL || c.mode == MODE_SHR) && $urandom_range(0, 3) != 0)
        begin
            c.operand_b = 64'($urandom_range(0, 70));
        end
        return c;
    endfunction

    initial
    begin
        alu_cmd_t c;
        bit gaps;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int op = 0; op <= 9; op++)
        begin
            c.mode      = 4'(op);
            c.is_signed = 1'(op % 2);
            c.policy    = 2'(op % 4);
            c.width     = (op % 3 == 0) ? 7'd64 : (op % 3 == 1) ? 7'd1 : 7'd8;
            c.operand_a = (op % 2) ? 64'h80 : '1;
            c.operand_b = (op == 3 || op == 4) ? 64'd0 : '1;
            send_beat(c, 1'b0);
        end
        c = '{MODE_DIV, 1'b1, POL_WRAP, 7'd8, 64'h80, 64'hff};
        send_beat(c, 1'b0);
        c = '{MODE_MOD, 1'b1, POL_SAT, 7'd64, 64'h8000_0000_0000_0000, '1};
        send_beat(c, 1'b0);
        c = '{MODE_NEG, 1'b1, POL_WRAP, 7'd16, 64'h8000, 64'd0};
        send_beat(c, 1'b0);
        c = '{MODE_NEG, 1'b1, POL_SAT, 7'd16, 64'h8000, 64'd0};
        send_beat(c, 1'b0);
        c = '{MODE_NEG, 1'b0, POL_SAT, 7'd16, 64'h5, 64'd0};
        send_beat(c, 1'b0);
        c = '{MODE_SHL, 1'b0, POL_CHECKED, 7'd0, 64'h1, 64'd0};
        send_beat(c, 1'b0);
        c = '{MODE_SHR, 1'b1, POL_UNUSED, 7'd100, '1, 64'd63};
        send_beat(c, 1'b0);
        c = '{MODE_SHL, 1'b0, POL_WRAP, 7'd8, 64'hff, 64'd8};
        send_beat(c, 1'b0);
        c = '{MODE_MUL, 1'b1, POL_SAT, 7'd8, 64'h80, 64'h2};
        send_beat(c, 1'b0);
        c = '{MODE_ADD, 1'b0, POL_SAT, 7'd64, '1, '1};
        send_beat(c, 1'b0);
        c = '{MODE_SUB, 1'b0, POL_SAT, 7'd32, 64'd0, 64'd1};
        send_beat(c, 1'b0);
        for (int i = 0; i < 1350; i++)
        begin
            if (i % 100 == 0)
            begin
                gaps = ($urandom_range(0, 2) != 0);
            end
            send_beat(random_cmd(), gaps);
        end
        start <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire
